>>> rtl/tagf_pkg.sv
// Shared types and constants for the time-aware gated descriptor FIFO.
// Holds the controller states, command and status bundles, status codes
// and register indexes. No dependencies.
package tagf_pkg;

  localparam int DEPTH_DEF    = 256;
  localparam int TAG_BITS_DEF = 16;

  localparam int NOW_W  = 63;
  localparam int SIZE_W = 16;
  localparam int CNT_W  = 9;
  localparam int DUR_W  = 48;
  localparam int WIN_W  = 51;

  localparam logic [63:0] FIT_LIMIT  = 64'd1 << 40;
  localparam logic [9:0]  PS_PER_NS  = 10'd1000;

  localparam logic        GATE_OPEN_RST  = 1'b1;
  localparam logic [63:0] CLOSE_TIME_RST = '1;
  localparam logic [31:0] BYTE_TIME_RST  = 32'd5333333;
  localparam logic [63:0] LIFETIME_RST   = '1;
  localparam logic [8:0]  CAPACITY_RST   = 9'd256;

  localparam logic [2:0] REG_GATE_OPEN  = 3'd0;
  localparam logic [2:0] REG_CLOSE_TIME = 3'd1;
  localparam logic [2:0] REG_BYTE_TIME  = 3'd2;
  localparam logic [2:0] REG_LIFETIME   = 3'd3;
  localparam logic [2:0] REG_CAPACITY   = 3'd4;

  localparam logic OP_ENQ = 1'b0;

  localparam logic [2:0] ST_ENQ    = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_DEQ    = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_CLOSED = 3'd4;
  localparam logic [2:0] ST_NOFIT  = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_AGE,
    S_WAIT,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic latch;
    logic drop;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic age_hit;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/tagf_ctrl.sv
// Sequencer for the gated descriptor FIFO.
// Steps each beat through aging and commit; depends on tagf_pkg.
module tagf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tagf_pkg::sts_t sts,
  output tagf_pkg::cmd_t cmd
);
  import tagf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_AGE;
      end
      S_AGE: begin
        state_next = sts.age_hit ? S_WAIT : S_EXEC;
      end
      S_WAIT: begin
        state_next = S_AGE;
      end
      S_EXEC: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_AGE: begin
        cmd.drop = sts.age_hit;
      end
      S_WAIT: begin
      end
      S_EXEC: begin
        cmd.exec = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/tagf_dp.sv
// Datapath of the gated descriptor FIFO: configuration registers, slot
// memory, aging and fit arithmetic, result register. Depends on tagf_pkg.
module tagf_dp #(
  parameter int DEPTH    = tagf_pkg::DEPTH_DEF,
  parameter int TAG_BITS = tagf_pkg::TAG_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [2:0]                   cfg_index,
  input  logic [63:0]                  cfg_data,
  input  logic                         operation,
  input  logic [tagf_pkg::NOW_W-1:0]   now,
  input  logic [TAG_BITS-1:0]          packet_tag,
  input  logic [tagf_pkg::SIZE_W-1:0]  packet_size,
  input  tagf_pkg::cmd_t               cmd,
  output tagf_pkg::sts_t               sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   status,
  output logic [tagf_pkg::CNT_W-1:0]   aged_drops,
  output logic [TAG_BITS-1:0]          out_tag,
  output logic [tagf_pkg::SIZE_W-1:0]  out_size,
  output logic [tagf_pkg::CNT_W-1:0]   occupancy
);
  import tagf_pkg::*;

  localparam int IW   = $clog2(DEPTH);
  localparam int FW   = $clog2(DEPTH + 1);
  localparam int CMPW = (FW > CNT_W) ? FW : CNT_W;
  localparam int MW   = TAG_BITS + SIZE_W + NOW_W;

  logic        gate_open;
  logic [63:0] close_time;
  logic [31:0] byte_time_ps;
  logic [63:0] lifetime;
  logic [8:0]  capacity;

  logic                op_q;
  logic [NOW_W-1:0]    now_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [SIZE_W-1:0]   size_q;

  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd;

  logic [IW-1:0]    head;
  logic [IW-1:0]    tail;
  logic [FW-1:0]    fill;
  logic [CNT_W-1:0] drops;

  logic [DUR_W-1:0] dur;
  logic             win_le;
  logic             win_eq;
  logic             win_big;
  logic [WIN_W-1:0] win_ps;

  logic [TAG_BITS-1:0] rd_tag;
  logic [SIZE_W-1:0]   rd_size;
  logic [NOW_W-1:0]    rd_stamp;
  logic                aging_en;
  logic [63:0]         age_sum;
  logic [63:0]         now_ext;
  logic [63:0]         window;
  logic                close_pos;
  logic                fits;
  logic [CMPW-1:0]     cap_ext;
  logic [CMPW-1:0]     cap_sat;
  logic                full;
  logic [IW-1:0]       head_inc;
  logic [IW-1:0]       tail_inc;

  logic [2:0]          res_status;
  logic                do_write;
  logic                do_pop;

  assign rd_tag   = rd[MW-1 -: TAG_BITS];
  assign rd_size  = rd[NOW_W +: SIZE_W];
  assign rd_stamp = rd[NOW_W-1:0];

  assign now_ext  = {1'b0, now_q};
  assign aging_en = !lifetime[63] && (lifetime != '0);
  assign age_sum  = {1'b0, rd_stamp} + lifetime;

  assign sts.age_hit  = aging_en && (fill != '0) && (age_sum < now_ext);
  assign sts.out_free = !out_valid || out_ready;

  assign window    = close_time - now_ext;
  assign close_pos = !close_time[63] && (close_time != '0);
  assign fits      = win_le ? (win_eq && (dur == '0))
                            : (win_big || (WIN_W'(dur) <= win_ps));

  assign cap_ext = CMPW'(capacity);
  assign cap_sat = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
  assign full    = CMPW'(fill) >= cap_sat;

  assign head_inc = (head == IW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == IW'(DEPTH - 1)) ? '0 : tail + 1'b1;

  always_comb begin
    do_write   = 1'b0;
    do_pop     = 1'b0;
    res_status = ST_ENQ;
    priority if (op_q == OP_ENQ) begin
      if (full) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_ENQ;
        do_write   = 1'b1;
      end
    end else if (fill == '0) begin
      res_status = ST_EMPTY;
    end else if (!gate_open) begin
      res_status = ST_CLOSED;
    end else if (close_pos && !fits) begin
      res_status = ST_NOFIT;
    end else begin
      res_status = ST_DEQ;
      do_pop     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_open    <= GATE_OPEN_RST;
      close_time   <= CLOSE_TIME_RST;
      byte_time_ps <= BYTE_TIME_RST;
      lifetime     <= LIFETIME_RST;
      capacity     <= CAPACITY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GATE_OPEN:  gate_open    <= cfg_data[0];
        REG_CLOSE_TIME: close_time   <= cfg_data;
        REG_BYTE_TIME:  byte_time_ps <= cfg_data[31:0];
        REG_LIFETIME:   lifetime     <= cfg_data;
        REG_CAPACITY:   capacity     <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= operation;
      now_q  <= now;
      tag_q  <= packet_tag;
      size_q <= packet_size;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_write) begin
      mem[tail] <= {tag_q, size_q, now_q};
    end
    rd <= mem[head];
  end

  always_ff @(posedge clk) begin
    dur     <= DUR_W'(rd_size) * DUR_W'(byte_time_ps);
    win_le  <= close_time <= now_ext;
    win_eq  <= close_time == now_ext;
    win_big <= window > FIT_LIMIT;
    win_ps  <= WIN_W'(window[40:0]) * WIN_W'(PS_PER_NS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
      drops <= '0;
    end else begin
      if (cmd.latch) begin
        drops <= '0;
      end else if (cmd.drop) begin
        drops <= drops + 1'b1;
      end
      if (cmd.drop || (cmd.exec && do_pop)) begin
        head <= head_inc;
        fill <= fill - 1'b1;
      end else if (cmd.exec && do_write) begin
        tail <= tail_inc;
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status     <= res_status;
      aged_drops <= drops;
      out_tag    <= do_pop ? rd_tag : '0;
      out_size   <= do_pop ? rd_size : '0;
      if (do_pop) begin
        occupancy <= CNT_W'(fill - 1'b1);
      end else if (do_write) begin
        occupancy <= CNT_W'(fill + 1'b1);
      end else begin
        occupancy <= CNT_W'(fill);
      end
    end
  end

endmodule

>>> rtl/time_aware_gated_fifo_top.sv
// A beat is latched in idle, checked for aging, then committed in the exec state
// once the result register is free; a new beat is taken only after that commit.
// An aged head drop waits on the registered slot memory read at the new head.
// The result register frees the input side while a result waits.
// Reset: pointers, fill and drop count cleared, registers to defaults;
// slot memory is not cleared (only written slots are ever used).
module time_aware_gated_fifo_top #(
  parameter int DEPTH    = tagf_pkg::DEPTH_DEF,
  parameter int TAG_BITS = tagf_pkg::TAG_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [63:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [tagf_pkg::NOW_W-1:0]   now,
  input  logic [TAG_BITS-1:0]          packet_tag,
  input  logic [tagf_pkg::SIZE_W-1:0]  packet_size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   status,
  output logic [tagf_pkg::CNT_W-1:0]   aged_drops,
  output logic [TAG_BITS-1:0]          out_tag,
  output logic [tagf_pkg::SIZE_W-1:0]  out_size,
  output logic [tagf_pkg::CNT_W-1:0]   occupancy
);
  import tagf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tagf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tagf_dp #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .now         (now),
    .packet_tag  (packet_tag),
    .packet_size (packet_size),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .aged_drops  (aged_drops),
    .out_tag     (out_tag),
    .out_size    (out_size),
    .occupancy   (occupancy)
  );

  a_exec_free: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!out_valid || out_ready))
    else $error("result committed over an untaken result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted while one is in flight");

  a_zero_unless_deq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_DEQ)) |-> (out_tag == '0 && out_size == '0))
    else $error("descriptor shown without a dequeue");

endmodule

>>> tb/tagf_gate_checker.sv
// Result checker for the time-aware gated descriptor FIFO: keeps its own copy of
// the queue, the aging and the transmission gate, and compares result beats in order.
// Depends on tagf_pkg; instantiated beside the block by time_aware_gated_fifo_top_tb.
module tagf_gate_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        operation,
  input  logic [62:0] now,
  input  logic [15:0] packet_tag,
  input  logic [15:0] packet_size,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [8:0]  aged_drops,
  input  logic [15:0] out_tag,
  input  logic [15:0] out_size,
  input  logic [8:0]  occupancy,
  output int          failures,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import tagf_pkg::*;

  localparam int SLOTS = 256;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  drops;
    logic [15:0] tag;
    logic [15:0] size;
    logic [8:0]  occupancy;
  } tagf_reply_t;

  logic [15:0] slot_tag_m   [SLOTS];
  logic [15:0] slot_size_m  [SLOTS];
  logic [62:0] slot_stamp_m [SLOTS];
  logic [7:0]  head_ix;
  logic [7:0]  tail_ix;
  int          held;

  logic        gate_open_r;
  logic [63:0] close_time_r;
  logic [31:0] byte_time_r;
  logic [63:0] lifetime_r;
  logic [8:0]  capacity_r;

  tagf_reply_t descriptor_replies [$];
  tagf_reply_t awaited;
  int          mismatches = 0;

  function automatic logic positive_span(input logic [63:0] v);
    return v != 64'd0 && !v[63];
  endfunction

  function automatic tagf_reply_t gate_step(input logic op, input logic [62:0] t,
                                            input logic [15:0] tag, input logic [15:0] sz);
    tagf_reply_t r;
    int          cap;
    logic [63:0] dur;
    logic [63:0] window;
    logic [63:0] t64;
    logic        fits;
    r   = '0;
    t64 = {1'b0, t};
    cap = (int'(capacity_r) > SLOTS) ? SLOTS : int'(capacity_r);
    if (positive_span(lifetime_r)) begin
      while (held > 0 && ({1'b0, slot_stamp_m[head_ix]} + lifetime_r) < t64) begin
        head_ix = head_ix + 8'd1;
        held    = held - 1;
        r.drops = r.drops + 9'd1;
      end
    end
    if (op == OP_ENQ) begin
      if (held >= cap) begin
        r.status = ST_FULL;
      end else begin
        slot_tag_m[tail_ix]   = tag;
        slot_size_m[tail_ix]  = sz;
        slot_stamp_m[tail_ix] = t;
        tail_ix  = tail_ix + 8'd1;
        held     = held + 1;
        r.status = ST_ENQ;
      end
    end else if (held == 0) begin
      r.status = ST_EMPTY;
    end else if (!gate_open_r) begin
      r.status = ST_CLOSED;
    end else begin
      fits = 1'b1;
      if (positive_span(close_time_r)) begin
        dur = 64'(slot_size_m[head_ix]) * 64'(byte_time_r);
        if (close_time_r <= t64) begin
          fits = (close_time_r == t64) && (dur == 64'd0);
        end else begin
          window = close_time_r - t64;
          fits   = (window > FIT_LIMIT) || (dur <= window * 64'(PS_PER_NS));
        end
      end
      if (!fits) begin
        r.status = ST_NOFIT;
      end else begin
        r.tag    = slot_tag_m[head_ix];
        r.size   = slot_size_m[head_ix];
        head_ix  = head_ix + 8'd1;
        held     = held - 1;
        r.status = ST_DEQ;
      end
    end
    r.occupancy = 9'(held);
    return r;
  endfunction

  task automatic compare_field(input string field, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_ix      = '0;
      tail_ix      = '0;
      held         = 0;
      gate_open_r  = GATE_OPEN_RST;
      close_time_r = CLOSE_TIME_RST;
      byte_time_r  = BYTE_TIME_RST;
      lifetime_r   = LIFETIME_RST;
      capacity_r   = CAPACITY_RST;
      descriptor_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GATE_OPEN:  gate_open_r  = cfg_data[0];
          REG_CLOSE_TIME: close_time_r = cfg_data;
          REG_BYTE_TIME:  byte_time_r  = cfg_data[31:0];
          REG_LIFETIME:   lifetime_r   = cfg_data;
          REG_CAPACITY:   capacity_r   = cfg_data[8:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (descriptor_replies.size() == 0) begin
          $display("%0t: result beat with nothing awaited (status %0d, occupancy %0d)",
                   $time, status, occupancy);
          mismatches++;
        end else begin
          awaited = descriptor_replies.pop_front();
          compare_field("status", awaited.status, status);
          compare_field("aged_drops", awaited.drops, aged_drops);
          compare_field("out_tag", awaited.tag, out_tag);
          compare_field("out_size", awaited.size, out_size);
          compare_field("occupancy", awaited.occupancy, occupancy);
        end
      end
      if (in_valid && in_ready)
        descriptor_replies.push_back(gate_step(operation, now, packet_tag, packet_size));
    end
    failures    <= mismatches;
    outstanding <= descriptor_replies.size();
  end

endmodule

>>> tb/time_aware_gated_fifo_top_tb.sv
// Testbench top for the time-aware gated descriptor FIFO: resets the block, drives
// directed and random beats through bursty input and stalling output, gives the verdict.
// Depends on tagf_pkg, time_aware_gated_fifo_top and tagf_gate_checker.
module time_aware_gated_fifo_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tagf_pkg::*;

  localparam logic OP_DEQ        = ~OP_ENQ;
  localparam int   CYCLE_LIMIT   = 300000;
  localparam int   ITEM_TARGET   = 650;
  localparam int   SETTLE_CYCLES = 20;
  localparam logic [62:0] NOW_MAX = '1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = OP_ENQ;
  logic [62:0] now = '0;
  logic [15:0] packet_tag = '0;
  logic [15:0] packet_size = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [8:0]  aged_drops;
  logic [15:0] out_tag;
  logic [15:0] out_size;
  logic [8:0]  occupancy;
  int          failures;
  int          outstanding;

  int          cycle_count = 0;
  int          burst_left = 0;
  int          items_sent = 0;
  logic [63:0] cur_now = '0;
  logic [7:0]  stall_pat = 8'hFF;
  int          stall_pos = 0;

  time_aware_gated_fifo_top DUT (.*);
  tagf_gate_checker u_checker (.*);

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: cycle through an 8-bit stall pattern, redrawn each time stall_pos wraps
  always @(posedge clk) begin
    if (stall_pos == 63) begin
      stall_pos <= 0;
      stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end else begin
      stall_pos <= stall_pos + 1;
    end
    out_ready <= stall_pat[stall_pos[2:0]];
  end

  task automatic send_beat(input logic op, input logic [62:0] t,
                           input logic [15:0] tag, input logic [15:0] sz);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    now         <= t;
    packet_tag  <= tag;
    packet_size <= sz;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic gate, input logic [63:0] close, input logic [31:0] bt,
                           input logic [63:0] life, input logic [8:0] cap);
    drain();
    write_reg(REG_GATE_OPEN, {63'({$urandom, $urandom}), gate});
    write_reg(REG_CLOSE_TIME, close);
    write_reg(REG_BYTE_TIME, {$urandom, bt});
    write_reg(REG_LIFETIME, life);
    write_reg(REG_CAPACITY, {55'({$urandom, $urandom}), cap});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_beat(input int enq_pct);
    logic        op;
    logic [62:0] t;
    logic [15:0] sz;
    op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
    cur_now = cur_now + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 5000)
                                                      : $urandom_range(0, 150));
    t = cur_now[62:0];
    if ($urandom_range(0, 49) == 0)
      t = 63'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0:       sz = '0;
      1, 2:    sz = 16'($urandom);
      default: sz = 16'($urandom_range(0, 2000));
    endcase
    send_beat(op, t, 16'($urandom), sz);
  endtask

  initial begin
    logic        gate;
    logic [63:0] close;
    logic [31:0] bt;
    logic [63:0] life;
    logic [8:0]  cap;
    int          span;
    int          enq_pct;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_beat(OP_DEQ, '0, 16'hFFFF, 16'hFFFF);
    send_beat(OP_ENQ, '0, 16'h0000, 16'h0000);
    send_beat(OP_ENQ, NOW_MAX, 16'hFFFF, 16'hFFFF);
    send_beat(OP_DEQ, NOW_MAX, '0, '0);
    send_beat(OP_DEQ, '0, '0, '0);
    send_beat(OP_DEQ, '0, '0, '0);

    configure(1'b0, '1, 32'd5333333, '1, 9'd2);
    send_beat(OP_ENQ, 63'd10, 16'h1234, 16'd64);
    send_beat(OP_ENQ, 63'd20, 16'h5678, 16'd128);
    send_beat(OP_ENQ, 63'd30, 16'h9ABC, 16'd256);
    send_beat(OP_DEQ, 63'd40, '0, '0);

    configure(1'b1, '1, 32'd5333333, '1, 9'd0);
    send_beat(OP_ENQ, 63'd50, 16'hDEAD, 16'd1);
    send_beat(OP_DEQ, 63'd60, '0, '0);
    send_beat(OP_DEQ, 63'd70, '0, '0);

    configure(1'b1, 64'd1000, 32'd1000, '1, 9'd511);
    send_beat(OP_ENQ, 63'd0, 16'h0101, 16'd0);
    send_beat(OP_ENQ, 63'd0, 16'h0202, 16'd500);
    send_beat(OP_DEQ, 63'd1000, '0, '0);
    send_beat(OP_DEQ, 63'd600, '0, '0);
    send_beat(OP_DEQ, 63'd500, '0, '0);
    send_beat(OP_ENQ, 63'd0, 16'h0303, 16'd0);
    send_beat(OP_DEQ, 63'd2000, '0, '0);

    configure(1'b1, 64'd1 << 62, 32'hFFFF_FFFF, '1, 9'd256);
    send_beat(OP_ENQ, 63'd3000, 16'h0404, 16'hFFFF);
    send_beat(OP_DEQ, 63'd3000, '0, '0);
    send_beat(OP_DEQ, 63'd3000, '0, '0);

    configure(1'b1, '1, 32'd5333333, 64'd100, 9'd256);
    send_beat(OP_ENQ, 63'd5000, 16'h0505, 16'd10);
    send_beat(OP_ENQ, 63'd5010, 16'h0606, 16'd20);
    send_beat(OP_ENQ, 63'd5020, 16'h0707, 16'd30);
    send_beat(OP_ENQ, 63'd5200, 16'h0808, 16'd40);
    cur_now = 64'd10000;

    // fill to the brim with a capacity above the slot count
    configure(1'b1, '1, 32'($urandom_range(1, 20000)), '1, 9'd300);
    repeat (280) random_beat(95);

    while (items_sent < ITEM_TARGET) begin
      gate = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0:       close = '1;
        1:       close = '0;
        2:       close = cur_now + $urandom_range(0, 20000);
        3:       close = 64'd1 << 62;
        4:       close = cur_now + FIT_LIMIT;
        default: close = cur_now + $urandom_range(0, 2000000);
      endcase
      case ($urandom_range(0, 4))
        0:       bt = 32'd1;
        1:       bt = 32'hFFFF_FFFF;
        2:       bt = 32'd5333333;
        3:       bt = $urandom_range(1, 2000);
        default: bt = $urandom_range(1, 20000);
      endcase
      case ($urandom_range(0, 5))
        0:       life = '1;
        1:       life = '0;
        2:       life = 64'd1 << 62;
        3:       life = {1'b1, 63'({$urandom, $urandom})};
        4:       life = $urandom_range(1, 300);
        default: life = $urandom_range(1, 3000);
      endcase
      case ($urandom_range(0, 5))
        0:       cap = 9'd0;
        1:       cap = 9'd1;
        2:       cap = 9'd256;
        3:       cap = 9'd511;
        4:       cap = 9'($urandom_range(17, 255));
        default: cap = 9'($urandom_range(2, 16));
      endcase
      configure(gate, close, bt, life, cap);
      span    = $urandom_range(20, 50);
      enq_pct = $urandom_range(30, 80);
      repeat (span) random_beat(enq_pct);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
